[hdl/upd_pkg.sv]
// Shared types, character codes and hex helpers for the URL percent decoder.
package upd_pkg;

  // Window holds up to five pending bytes plus the newly transferred one.
  localparam int unsigned WinDepth = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrPct   = 8'h25;
  localparam logic [7:0] ChrLowU  = 8'h75;
  localparam logic [7:0] ChrUpU   = 8'h55;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrSpace = 8'h20;

  // Bytes consumed by one scan step.
  localparam logic [CntW-1:0] UsedOne = 3'd1;
  localparam logic [CntW-1:0] UsedPct = 3'd3;
  localparam logic [CntW-1:0] UsedUni = 3'd6;

  typedef struct packed {
    logic load;    // transfer a new input byte into the window
    logic step;    // consume the head of the window
    logic finish;  // release the held result and end the item
  } upd_cmd_t;

  typedef struct packed {
    logic stop;      // head cannot be settled yet, or window is empty
    logic have;      // head step yields a result byte
    logic hold_vld;  // a result is waiting in the hold register
    logic out_free;  // output register can take a byte this cycle
  } upd_sts_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    return (c[6]) ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic [7:0] clean_byte(input logic [7:0] c);
    return (c == ChrCr || c == ChrLf) ? ChrSpace : c;
  endfunction

endpackage

[hdl/url_percent_decoder_top.sv]
// Top level of the streaming URL percent decoder.
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one encoded byte with
//   in_last_i marking the final byte of a packet. Output channel
//   (out_valid_o/out_ready_i) transfers decoded bytes; out_last_o marks the
//   final decoded byte of a packet (a packet whose end yields nothing has
//   no marked byte).
//   '+' decodes to space, %XX and %uWXYZ to a byte, CR/LF to space. Bytes
//   of an undecided escape wait in a six-entry window.
// Timing:
//   One byte at a time. After a transfer the scan steps through the window,
//   one step per cycle unless a stalled output register holds it, and a
//   closing step ends the item and lets the next byte in. The head decode
//   of the window sets each step.
//   The first result of an item goes to the hold register and moves to the
//   output register with the next result or the closing step.
// Reset: window count and the hold and output valid flags clear; no output valid.
// Stall: a stalled output register stops the scan whenever the held result
//   has to move into it (a second result, or the closing cycle); other
//   steps go on.
module url_percent_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  upd_pkg::upd_cmd_t cmd;
  upd_pkg::upd_sts_t sts;

  // Sequencer: idle/scan.
  upd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window, decoder and output stage.
  upd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Hold register is drained before a new byte is taken.
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.hold_vld)
    else $error("hold register busy while accepting input");

  // A transfer starts a scan; no second byte right after.
  a_load_then_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // Commands are exclusive.
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.step && cmd.finish) && !(cmd.load && (cmd.step || cmd.finish)))
    else $error("conflicting datapath commands");

  // Finishing an item releases the held result.
  a_finish_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> !sts.hold_vld && in_ready_o)
    else $error("held result left after item end");

endmodule

[hdl/upd_ctrl.sv]
// Control state machine of the URL percent decoder.
module upd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  upd_pkg::upd_sts_t sts_i,
  output upd_pkg::upd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.stop) begin
          if (!sts_i.hold_vld || sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (!(sts_i.have && sts_i.hold_vld) || sts_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/upd_datapath.sv]
// Window, head decode, hold and output registers of the URL percent decoder.
module upd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  input  upd_pkg::upd_cmd_t cmd_i,
  output upd_pkg::upd_sts_t sts_o
);

  localparam int unsigned Depth = upd_pkg::WinDepth;
  localparam int unsigned CntW  = upd_pkg::CntW;

  logic [7:0]      win_q [Depth];
  logic [7:0]      win_d [Depth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last_q, last_d;
  logic [7:0]      hold_q, hold_d;
  logic            hold_vld_q, hold_vld_d;
  logic [7:0]      obyte_q, obyte_d;
  logic            olast_q, olast_d;
  logic            ovld_q, ovld_d;

  logic            dec_stop, dec_have;
  logic [7:0]      dec_val;
  logic [CntW-1:0] dec_used;
  logic            out_free;

  // Head decode: one step of the scan over the window.
  always_comb begin
    dec_stop = 1'b0;
    dec_have = 1'b0;
    dec_val  = upd_pkg::ChrPct;
    dec_used = upd_pkg::UsedOne;
    if (cnt_q == '0) begin
      dec_stop = 1'b1;
    end else if (win_q[0] == upd_pkg::ChrPlus) begin
      dec_have = 1'b1;
      dec_val  = upd_pkg::ChrSpace;
    end else if (win_q[0] != upd_pkg::ChrPct) begin
      dec_have = 1'b1;
      dec_val  = upd_pkg::clean_byte(win_q[0]);
    end else if (cnt_q < CntW'(2)) begin
      if (!last_q) dec_stop = 1'b1;
      else dec_have = 1'b1;
    end else if (win_q[1] == upd_pkg::ChrLowU || win_q[1] == upd_pkg::ChrUpU) begin
      if (cnt_q < CntW'(6)) begin
        if (!last_q) dec_stop = 1'b1;
      end else if (upd_pkg::is_hex(win_q[4]) && upd_pkg::is_hex(win_q[5])) begin
        dec_have = 1'b1;
        dec_val  = upd_pkg::clean_byte({upd_pkg::hex_nib(win_q[4]),
                                        upd_pkg::hex_nib(win_q[5])});
        dec_used = upd_pkg::UsedUni;
      end
    end else if (cnt_q < CntW'(3)) begin
      if (!last_q) dec_stop = 1'b1;
      else dec_have = 1'b1;
    end else if (upd_pkg::is_hex(win_q[1]) && upd_pkg::is_hex(win_q[2])) begin
      dec_have = 1'b1;
      dec_val  = upd_pkg::clean_byte({upd_pkg::hex_nib(win_q[1]),
                                      upd_pkg::hex_nib(win_q[2])});
      dec_used = upd_pkg::UsedPct;
    end
  end

  assign out_free = !ovld_q || out_ready_i;

  always_comb begin
    win_d      = win_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    obyte_d    = obyte_q;
    olast_d    = olast_q;
    ovld_d     = ovld_q && !out_ready_i;

    if (cmd_i.load) begin
      for (int i = 0; i < Depth; i++) begin
        if (cnt_q == CntW'(i)) win_d[i] = in_byte_i;
      end
      cnt_d  = cnt_q + CntW'(1);
      last_d = in_last_i;
    end

    if (cmd_i.step) begin
      // Results trail by one so the final one can carry the last flag.
      if (dec_have) begin
        if (hold_vld_q) begin
          obyte_d = hold_q;
          olast_d = 1'b0;
          ovld_d  = 1'b1;
        end
        hold_d     = dec_val;
        hold_vld_d = 1'b1;
      end
      case (dec_used)
        upd_pkg::UsedPct: begin
          for (int i = 0; i < Depth - 3; i++) win_d[i] = win_q[i + 3];
        end
        upd_pkg::UsedUni: ;
        default: begin
          for (int i = 0; i < Depth - 1; i++) win_d[i] = win_q[i + 1];
        end
      endcase
      cnt_d = cnt_q - dec_used;
    end

    if (cmd_i.finish && hold_vld_q) begin
      obyte_d    = hold_q;
      olast_d    = last_q;
      ovld_d     = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      hold_vld_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      hold_vld_q <= hold_vld_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    last_q  <= last_d;
    hold_q  <= hold_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign sts_o.stop     = dec_stop;
  assign sts_o.have     = dec_have;
  assign sts_o.hold_vld = hold_vld_q;
  assign sts_o.out_free = out_free;

  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

[tb/url_percent_decoder_top_tb.sv]
// Self-checking testbench for the streaming URL percent decoder.
module url_percent_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChrDigit0 = 8'h30;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrLowerA = 8'h61;
  localparam int unsigned HeldMax    = 5;
  localparam int unsigned PhaseCnt   = 8;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned TailCycles = 32;
  localparam int unsigned QuietLimit = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } dec_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
  } enc_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  url_percent_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  enc_item_t  encoded_q[$];   // bytes waiting to be driven
  dec_byte_t  decoded_q[$];   // decoded bytes still owed by the block
  logic [7:0] pkt_q[$];       // packet under construction

  logic [7:0] held_bytes [HeldMax];
  int         held_cnt = 0;

  int  in_idle_max = 0;
  int  out_idle_max = 0;
  int  sink_wait = 0;
  int  queued_cnt = 0;
  int  accepted_cnt = 0;
  int  quiet_cycles = 0;
  int  errors = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] no_newline(input logic [7:0] c);
    return (c == upd_pkg::ChrCr || c == upd_pkg::ChrLf) ? upd_pkg::ChrSpace : c;
  endfunction

  function automatic logic [7:0] pair_byte(input logic [7:0] hi, input logic [7:0] lo);
    return 8'(hex_value(hi) * 16 + hex_value(lo));
  endfunction

  // Runs the window scan for one accepted byte and queues what it settles.
  function automatic void decode_transfer(input logic [7:0] b, input logic fin);
    logic [7:0] w [HeldMax + 1];
    logic [7:0] val;
    logic       have;
    logic       stall;
    int         n;
    int         used;
    int         k;
    n = held_cnt;
    for (int i = 0; i < n; i++) w[i] = held_bytes[i];
    w[n] = b;
    n++;
    k = 0;
    stall = 1'b0;
    while (n > 0 && !stall) begin
      have = 1'b0;
      val = 8'h00;
      used = 1;
      if (w[0] == upd_pkg::ChrPlus) begin
        have = 1'b1;
        val = upd_pkg::ChrSpace;
      end else if (w[0] != upd_pkg::ChrPct) begin
        have = 1'b1;
        val = no_newline(w[0]);
      end else if (n < 2) begin
        if (!fin) stall = 1'b1;
        else begin
          have = 1'b1;
          val = upd_pkg::ChrPct;
        end
      end else if (w[1] == upd_pkg::ChrLowU || w[1] == upd_pkg::ChrUpU) begin
        // u-escape: only the last two of its six bytes are checked
        if (n < 6) begin
          if (!fin) stall = 1'b1;
        end else if (hex_value(w[4]) >= 0 && hex_value(w[5]) >= 0) begin
          have = 1'b1;
          val = no_newline(pair_byte(w[4], w[5]));
          used = 6;
        end
      end else if (n < 3) begin
        if (!fin) stall = 1'b1;
        else begin
          have = 1'b1;
          val = upd_pkg::ChrPct;
        end
      end else if (hex_value(w[1]) >= 0 && hex_value(w[2]) >= 0) begin
        have = 1'b1;
        val = no_newline(pair_byte(w[1], w[2]));
        used = 3;
      end
      if (!stall) begin
        if (have && k < 6) begin
          decoded_q.push_back('{data: val, fin: 1'b0});
          k++;
        end
        for (int i = 0; i < n - used; i++) w[i] = w[i + used];
        n -= used;
      end
    end
    if (n > HeldMax) n = HeldMax;
    for (int i = 0; i < n; i++) held_bytes[i] = w[i];
    held_cnt = n;
    if (fin && k > 0) decoded_q[decoded_q.size() - 1].fin = 1'b1;
  endfunction

  // Stimulus helpers
  task automatic push_byte(input logic [7:0] b, input logic fin);
    encoded_q.push_back('{data: b, fin: fin, gap: $urandom_range(0, in_idle_max)});
    queued_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input int nib);
    if (nib < 10) return ChrDigit0 + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? ChrLowerA : ChrUpperA) + 8'(nib - 10);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_value(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_u();
    return ($urandom_range(0, 1) != 0) ? upd_pkg::ChrLowU : upd_pkg::ChrUpU;
  endfunction

  task automatic add_token();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: pkt_q.push_back(8'($urandom_range(0, 255)));
      1: pkt_q.push_back(upd_pkg::ChrPlus);
      2: pkt_q.push_back(($urandom_range(0, 1) != 0) ? upd_pkg::ChrCr : upd_pkg::ChrLf);
      3, 4: begin
        pkt_q.push_back(upd_pkg::ChrPct);
        pkt_q.push_back(hex_char($urandom_range(0, 15)));
        pkt_q.push_back(hex_char($urandom_range(0, 15)));
      end
      5: begin
        // escape that decodes to CR or LF
        pkt_q.push_back(upd_pkg::ChrPct);
        pkt_q.push_back(ChrDigit0);
        pkt_q.push_back(hex_char(($urandom_range(0, 1) != 0) ? 13 : 10));
      end
      6, 7: begin
        pkt_q.push_back(upd_pkg::ChrPct);
        pkt_q.push_back(rand_u());
        pkt_q.push_back(8'($urandom_range(0, 255)));
        pkt_q.push_back(8'($urandom_range(0, 255)));
        pkt_q.push_back(hex_char($urandom_range(0, 15)));
        pkt_q.push_back(hex_char($urandom_range(0, 15)));
      end
      8: begin
        pkt_q.push_back(upd_pkg::ChrPct);
        if ($urandom_range(0, 1) != 0) begin
          pkt_q.push_back(rand_nonhex());
          pkt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          pkt_q.push_back(hex_char($urandom_range(0, 15)));
          pkt_q.push_back(rand_nonhex());
        end
      end
      default: begin
        // u-escape with a bad digit in one of the checked places
        pkt_q.push_back(upd_pkg::ChrPct);
        pkt_q.push_back(rand_u());
        pkt_q.push_back(8'($urandom_range(0, 255)));
        pkt_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0) begin
          pkt_q.push_back(rand_nonhex());
          pkt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          pkt_q.push_back(hex_char($urandom_range(0, 15)));
          pkt_q.push_back(rand_nonhex());
        end
      end
    endcase
  endtask

  // Mostly well-formed token runs; some packets are cut short mid-escape.
  task automatic queue_random_packet();
    int cut;
    pkt_q.delete();
    repeat ($urandom_range(1, 6)) add_token();
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, pkt_q.size());
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
    foreach (pkt_q[i]) push_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // Holds off the sender until every byte is in and every result is out.
  task automatic wait_drained();
    @(negedge clk_i);
    while (accepted_cnt != queued_cnt || decoded_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Input driver: payload changes only at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (encoded_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (encoded_q[0].gap > 0) begin
        encoded_q[0].gap = encoded_q[0].gap - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_byte_i  <= encoded_q[0].data;
        in_last_i  <= encoded_q[0].fin;
        void'(encoded_q.pop_front());
      end
    end
  end

  // Output sink: draws a stall after each transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) sink_wait = $urandom_range(0, out_idle_max);
      if (sink_wait > 0) begin
        sink_wait = sink_wait - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni) begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        decode_transfer(in_byte_i, in_last_i);
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: expected no output, got byte %02h last %0b",
                   $time, out_byte_o, out_last_o);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_o !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte_o);
          end
          if (out_last_o !== want.fin) begin
            errors++;
            $display("%0t: out_last expected %0b, got %0b", $time, want.fin, out_last_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int in_gap_tab [PhaseCnt];
    int out_gap_tab [PhaseCnt];
    int phase_start;
    in_gap_tab  = '{0, 15, 0, 15, 3, 0, 15, 7};
    out_gap_tab = '{0, 0, 15, 15, 15, 3, 7, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes, every escape form and each corner case.
    in_idle_max  = 2;
    out_idle_max = 3;
    push_byte(upd_pkg::ChrPlus, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(upd_pkg::ChrCr, 1'b0);
    push_byte(upd_pkg::ChrLf, 1'b1);
    send_text("%4a%0D");   // hex pair, decoded CR
    send_text("%uzz41");   // u-escape with unchecked filler
    send_text("%g1");      // failed escape, rescan
    send_text("%U1");      // u-escape cut by packet end
    send_text("A%");       // lone percent at the end
    send_text("%4");       // percent with one byte before the end
    wait_drained();

    // Random part in phases with different idling; drain between phases.
    for (int p = 0; p < PhaseCnt; p++) begin
      in_idle_max  = in_gap_tab[p];
      out_idle_max = out_gap_tab[p];
      phase_start  = queued_cnt;
      while (queued_cnt - phase_start < PhaseItems) queue_random_packet();
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0t: %0d decoded bytes never arrived", $time, decoded_q.size());
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
hdl/upd_pkg.sv
hdl/upd_ctrl.sv
hdl/upd_datapath.sv
hdl/url_percent_decoder_top.sv
tb/url_percent_decoder_top_tb.sv
